// ----- rtl/core/ihpq_pkg.sv -----
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared types, constants and controller/datapath signal groups for the
// indexed heap priority queue.
// ----------------------------------------------------------------------------
package ihpq_pkg;

   localparam int DefCapacity = 64;
   localparam int DefKeyBits  = 32;
   localparam int HandleBits  = 6;
   localparam int CountBits   = 7;
   localparam int KeyPortBits = 32;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE_TOP = 3'd1,
      OP_REMOVE_HANDLE = 3'd2,
      OP_UPDATE = 3'd3,
      OP_PEEK = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FIND,      // scan for lowest free handle
      S_INS_WR,
      S_TOP_RD,    // read position 0
      S_TOP_WAIT,
      S_POS_RD,    // read position of a handle
      S_POS_WAIT,
      S_ENT_RD,    // read entry at cur
      S_ENT_WAIT,
      S_LAST_RD,   // read last entry
      S_LAST_WAIT,
      S_MOVE_WR,   // write last entry into the hole
      S_UPD_WR,
      S_NB_RD,     // read left child
      S_NB_L,      // left data back, read right child
      S_NB_R,      // right data back, read parent
      S_NB_P,      // parent data back
      S_DECIDE,
      S_SWAP_A,
      S_SWAP_B,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RA_CUR, RA_LEFT, RA_RIGHT, RA_PARENT
   } rsel_type;

   // controller to datapath
   typedef struct packed {
      logic      latch_req;
      logic      scan_clr;
      logic      scan_step;
      logic      rd_en;
      rsel_type  rd_sel;
      logic      rd_top;
      logic      rd_last;
      logic      rd_pos;
      logic      cap_cur;
      logic      cap_left;
      logic      cap_right;
      logic      cap_parent;
      logic      cap_pos;
      logic      cap_out;
      logic      ins_write;
      logic      move_write;
      logic      upd_write;
      logic      swap_a;
      logic      swap_b;
      logic      cnt_inc;
      logic      cnt_dec;
      logic      free_handle;
      logic      set_hole_cur;
      logic      go_down;
      logic      go_up;
      logic      set_err;
      status_type err;
      logic      rsp_fire;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      opcode_type op;
      logic empty;
      logic full;
      logic handle_ok;
      logic pos_ok;
      logic scan_hit;
      logic scan_end;
      logic is_last;
      logic hole_live;
      logic want_down;
      logic want_up;
      logic down_ok;
      logic up_ok;
      logic sift_up_mode;
   } sts_type;

endpackage

// ----- rtl/core/ihpq_ram.sv -----
// ----------------------------------------------------------------------------
// ihpq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ihpq_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/ihpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ihpq_ctrl
// Sequencer for one queue operation: handle search, reads, moves, sift
// steps and the result strobe.
// ----------------------------------------------------------------------------
module ihpq_ctrl import ihpq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output ctl_type ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      ctl.rd_sel = RA_CUR;
      ctl.err = ST_OK;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch_req = 1'b1;
               ctl.scan_clr = 1'b1;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            // dispatch on latched opcode; also serves as handle scan for insert
            unique case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     ctl.set_err = 1'b1; ctl.err = ST_FULL; state_in = S_DONE;
                  end else if (sts.scan_hit) begin
                     state_in = S_INS_WR;
                  end else begin
                     ctl.scan_step = 1'b1;
                  end
               end
               OP_REMOVE_TOP, OP_PEEK: begin
                  if (sts.empty) begin
                     ctl.set_err = 1'b1; ctl.err = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     ctl.rd_en = 1'b1; ctl.rd_top = 1'b1; state_in = S_TOP_WAIT;
                  end
               end
               OP_REMOVE_HANDLE, OP_UPDATE: begin
                  if (!sts.handle_ok) begin
                     ctl.set_err = 1'b1; ctl.err = ST_BAD_HANDLE; state_in = S_DONE;
                  end else begin
                     ctl.rd_pos = 1'b1; state_in = S_POS_WAIT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_INS_WR: begin
            ctl.ins_write = 1'b1;
            ctl.cnt_inc = 1'b1;
            state_in = S_NB_RD;
         end
         S_TOP_WAIT: begin
            ctl.cap_cur = 1'b1;
            ctl.cap_out = 1'b1;
            state_in = (sts.op == OP_PEEK) ? S_DONE : S_LAST_RD;
         end
         S_POS_WAIT: begin
            ctl.cap_pos = 1'b1;
            state_in = S_ENT_RD;
         end
         S_ENT_RD: begin
            if (!sts.pos_ok) begin
               ctl.set_err = 1'b1; ctl.err = ST_BAD_HANDLE; state_in = S_DONE;
            end else if (sts.op == OP_UPDATE) begin
               state_in = S_UPD_WR;
            end else begin
               ctl.rd_en = 1'b1; state_in = S_ENT_WAIT;
            end
         end
         S_ENT_WAIT: begin
            ctl.cap_cur = 1'b1;
            ctl.cap_out = 1'b1;
            state_in = S_LAST_RD;
         end
         S_LAST_RD: begin
            ctl.free_handle = 1'b1;
            ctl.rd_en = 1'b1; ctl.rd_last = 1'b1;
            state_in = S_LAST_WAIT;
         end
         S_LAST_WAIT: begin
            ctl.cnt_dec = 1'b1;
            ctl.set_hole_cur = 1'b1;
            state_in = sts.is_last ? S_DONE : S_MOVE_WR;
         end
         S_MOVE_WR: begin
            ctl.move_write = 1'b1;
            state_in = S_NB_RD;
         end
         S_UPD_WR: begin
            ctl.upd_write = 1'b1;
            state_in = S_NB_RD;
         end
         S_NB_RD: begin
            ctl.rd_en = 1'b1; ctl.rd_sel = RA_LEFT;
            state_in = S_NB_L;
         end
         S_NB_L: begin
            ctl.cap_left = 1'b1;
            ctl.rd_en = 1'b1; ctl.rd_sel = RA_RIGHT;
            state_in = S_NB_R;
         end
         S_NB_R: begin
            ctl.cap_right = 1'b1;
            ctl.rd_en = 1'b1; ctl.rd_sel = RA_PARENT;
            state_in = S_NB_P;
         end
         S_NB_P: begin
            ctl.cap_parent = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.down_ok) begin
               ctl.go_down = 1'b1; state_in = S_SWAP_A;
            end else if (sts.up_ok) begin
               ctl.go_up = 1'b1; state_in = S_SWAP_A;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SWAP_A: begin
            ctl.swap_a = 1'b1;
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            ctl.swap_b = 1'b1;
            state_in = S_NB_RD;
         end
         S_DONE: begin
            ctl.rsp_fire = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ----- rtl/core/ihpq_dp.sv -----
// ----------------------------------------------------------------------------
// ihpq_dp
// Heap storage, handle bookkeeping, position arithmetic and key compares.
// ----------------------------------------------------------------------------
module ihpq_dp import ihpq_pkg::*; #(
   parameter int Capacity = DefCapacity,
   parameter int KeyBits  = DefKeyBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   min_first,
   input  logic [2:0]             req_opcode,
   input  logic [KeyPortBits-1:0] req_key,
   input  logic [HandleBits-1:0]  req_handle,
   input  ctl_type                ctl,
   output sts_type                sts,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [HandleBits-1:0]  rsp_out_handle,
   output logic [KeyPortBits-1:0] rsp_out_key,
   output logic [CountBits-1:0]   rsp_count
);
   localparam int AW = $clog2(Capacity);
   localparam int CW = $clog2(Capacity + 1);
   localparam int PW = AW + 2;   // room for 2*i+2

   function automatic logic [KeyBits-1:0] key_of(input logic [KeyPortBits-1:0] k);
      logic [63:0] w;
      w = 64'(k);
      return w[KeyBits-1:0];
   endfunction

   function automatic logic [KeyPortBits-1:0] key_out(input logic [KeyBits-1:0] k);
      logic [63:0] w;
      w = 64'(k);
      return w[KeyPortBits-1:0];
   endfunction

   // request
   opcode_type           op_ff;
   logic [KeyBits-1:0]   key_ff;
   logic [HandleBits-1:0] hin_ff;

   logic [CW-1:0]        count_ff;
   logic [Capacity-1:0]  in_use_ff;
   logic [CW-1:0]        scan_ff;

   // entry under repair
   logic [AW-1:0]        cur_ff;
   logic [KeyBits-1:0]   ck_ff;
   logic [AW-1:0]        ch_ff;
   logic [KeyBits-1:0]   lk_ff, rk_ff, pk_ff;
   logic [AW-1:0]        lh_ff, rh_ff, ph_ff;
   logic                 first_ff;   // first compare of repair
   logic                 upmode_ff;
   logic [AW-1:0]        tgt_ff;
   logic [KeyBits-1:0]   tk_ff;
   logic [AW-1:0]        th_ff;

   logic [1:0]           st_ff;
   logic [AW-1:0]        oh_ff;
   logic [KeyBits-1:0]   ok_ff;
   logic                 valid_ff;

   // memories
   logic          kwe, hwe, pwe;
   logic [AW-1:0] kwa, hwa, pwa, kra, pra;
   logic [KeyBits-1:0] kwd, krd;
   logic [AW-1:0] hwd, pwd, hrd, prd;

   ihpq_ram #(.Width(KeyBits), .Depth(Capacity)) u_keys (
      .clock(clock), .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(kra), .rdata(krd));
   ihpq_ram #(.Width(AW), .Depth(Capacity)) u_hnds (
      .clock(clock), .we(hwe), .waddr(hwa), .wdata(hwd), .raddr(kra), .rdata(hrd));
   ihpq_ram #(.Width(AW), .Depth(Capacity)) u_pos (
      .clock(clock), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

   // neighbor positions
   logic [PW-1:0] lpos, rpos, ppos;
   logic l_live, r_live, p_live;
   logic [PW-1:0] cnt_w;
   assign lpos = {1'b0, cur_ff, 1'b1};
   assign rpos = PW'({cur_ff, 1'b0}) + PW'(2);
   assign ppos = PW'((cur_ff - AW'(1)) >> 1);
   assign cnt_w = PW'(count_ff);
   assign l_live = lpos < cnt_w;
   assign r_live = rpos < cnt_w;
   assign p_live = cur_ff != '0;

   function automatic logic pref(input logic mf, input logic [KeyBits-1:0] a,
                                 input logic [KeyBits-1:0] b);
      return mf ? (a < b) : (a > b);
   endfunction

   logic l_pref, r_pref, rl_pref, up_pref;
   assign l_pref  = l_live && pref(min_first, lk_ff, ck_ff);
   assign r_pref  = r_live && pref(min_first, rk_ff, ck_ff);
   assign rl_pref = r_live && pref(min_first, rk_ff, lk_ff);
   assign up_pref = p_live && pref(min_first, ck_ff, pk_ff);

   // down: first step uses repair rule, later steps sift_down rule
   logic best_r, down_want, best_pref;
   assign best_r = rl_pref;
   assign best_pref = best_r ? r_pref : l_pref;
   assign down_want = first_ff ? (l_pref || r_pref) : (l_live && best_pref);
   // up allowed only on first step or when already in up mode
   // (in up mode the children are not looked at)
   logic do_down, do_up;
   assign do_down = !upmode_ff && down_want;
   assign do_up = up_pref && (upmode_ff || (first_ff && !down_want));

   // handle scan
   logic [AW-1:0] scan_idx;
   assign scan_idx = scan_ff[AW-1:0];

   // read address select
   always_comb begin
      kra = cur_ff;
      if (ctl.rd_top) kra = '0;
      else if (ctl.rd_last) kra = AW'(count_ff - CW'(1));
      else begin
         unique case (ctl.rd_sel)
            RA_CUR:    kra = cur_ff;
            RA_LEFT:   kra = lpos[AW-1:0];
            RA_RIGHT:  kra = rpos[AW-1:0];
            RA_PARENT: kra = ppos[AW-1:0];
            default:   kra = cur_ff;
         endcase
      end
   end
   assign pra = hin_ff[AW-1:0];

   // memory writes
   always_comb begin
      kwe = 1'b0; hwe = 1'b0; pwe = 1'b0;
      kwa = cur_ff; hwa = cur_ff; pwa = ch_ff;
      kwd = ck_ff; hwd = ch_ff; pwd = cur_ff;
      if (ctl.ins_write) begin
         kwe = 1'b1; hwe = 1'b1; pwe = 1'b1;
         kwa = AW'(count_ff); hwa = AW'(count_ff); pwa = scan_idx;
         kwd = key_ff; hwd = scan_idx; pwd = AW'(count_ff);
      end else if (ctl.move_write) begin
         // last entry (captured into l regs) moves into hole at cur
         kwe = 1'b1; hwe = 1'b1; pwe = 1'b1;
         kwa = cur_ff; hwa = cur_ff; pwa = lh_ff;
         kwd = lk_ff; hwd = lh_ff; pwd = cur_ff;
      end else if (ctl.upd_write) begin
         kwe = 1'b1;
         kwa = cur_ff; kwd = key_ff;
      end else if (ctl.swap_a) begin
         // target entry into cur position
         kwe = 1'b1; hwe = 1'b1; pwe = 1'b1;
         kwa = cur_ff; hwa = cur_ff; pwa = th_ff;
         kwd = tk_ff; hwd = th_ff; pwd = cur_ff;
      end else if (ctl.swap_b) begin
         kwe = 1'b1; hwe = 1'b1; pwe = 1'b1;
         kwa = tgt_ff; hwa = tgt_ff; pwa = ch_ff;
         kwd = ck_ff; hwd = ch_ff; pwd = tgt_ff;
      end
   end

   logic [AW-1:0] hin_a;
   assign hin_a = hin_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         in_use_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.rsp_fire;
         if (ctl.cnt_inc) count_ff <= count_ff + CW'(1);
         if (ctl.cnt_dec) count_ff <= count_ff - CW'(1);
         if (ctl.ins_write) in_use_ff[scan_idx] <= 1'b1;
         if (ctl.free_handle) in_use_ff[ch_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         op_ff <= opcode_type'(req_opcode);
         key_ff <= key_of(req_key);
         hin_ff <= req_handle;
         st_ff <= ST_OK;
         oh_ff <= '0;
         ok_ff <= '0;
      end
      if (ctl.scan_clr) scan_ff <= '0;
      else if (ctl.scan_step) scan_ff <= scan_ff + CW'(1);
      if (ctl.set_err) st_ff <= ctl.err;
      if (ctl.ins_write) begin
         cur_ff <= AW'(count_ff);
         ck_ff <= key_ff;
         ch_ff <= scan_idx;
         first_ff <= 1'b0;
         upmode_ff <= 1'b1;
         oh_ff <= scan_idx;
         ok_ff <= key_ff;
      end
      if (ctl.rd_top) cur_ff <= '0;
      if (ctl.cap_pos) cur_ff <= prd;
      if (ctl.cap_cur) begin
         ck_ff <= krd;
         ch_ff <= hrd;
      end
      if (ctl.cap_out) begin
         oh_ff <= hrd;
         ok_ff <= krd;
      end
      if (ctl.upd_write) begin
         ck_ff <= key_ff;
         ch_ff <= hin_a;
         first_ff <= 1'b1;
         upmode_ff <= 1'b0;
         oh_ff <= hin_a;
         ok_ff <= key_ff;
      end
      if (ctl.cap_left) begin
         lk_ff <= krd; lh_ff <= hrd;
      end
      if (ctl.cap_right) begin
         rk_ff <= krd; rh_ff <= hrd;
      end
      if (ctl.cap_parent) begin
         pk_ff <= krd; ph_ff <= hrd;
      end
      // last entry read lands in l regs and becomes the entry at the hole
      if (ctl.set_hole_cur) begin
         lk_ff <= krd; lh_ff <= hrd;
         first_ff <= 1'b1;
         upmode_ff <= 1'b0;
      end
      if (ctl.move_write) begin
         ck_ff <= lk_ff; ch_ff <= lh_ff;
      end
      if (ctl.go_down) begin
         tgt_ff <= best_r ? rpos[AW-1:0] : lpos[AW-1:0];
         tk_ff <= best_r ? rk_ff : lk_ff;
         th_ff <= best_r ? rh_ff : lh_ff;
      end
      if (ctl.go_up) begin
         tgt_ff <= ppos[AW-1:0];
         tk_ff <= pk_ff;
         th_ff <= ph_ff;
         upmode_ff <= 1'b1;
      end
      if (ctl.swap_b) begin
         cur_ff <= tgt_ff;
         first_ff <= 1'b0;
      end
   end

   assign sts.op = op_ff;
   assign sts.empty = count_ff == '0;
   assign sts.full = count_ff >= CW'(Capacity);
   assign sts.handle_ok = (32'(hin_ff) < 32'(Capacity)) && in_use_ff[hin_a];
   assign sts.pos_ok = CW'(cur_ff) < count_ff;
   assign sts.scan_hit = !in_use_ff[scan_idx];
   assign sts.scan_end = scan_ff >= CW'(Capacity);
   assign sts.is_last = CW'(cur_ff) == count_ff - CW'(1);
   assign sts.hole_live = CW'(cur_ff) < count_ff;
   assign sts.want_down = down_want;
   assign sts.want_up = up_pref;
   assign sts.down_ok = do_down;
   assign sts.up_ok = do_up;
   assign sts.sift_up_mode = upmode_ff;

   assign rsp_valid = valid_ff;
   assign rsp_status = st_ff;
   assign rsp_out_handle = HandleBits'(oh_ff);
   assign rsp_out_key = key_out(ok_ff);
   assign rsp_count = CountBits'(count_ff);
endmodule

// ----- rtl/core/indexed_heap_priority_queue_top.sv -----
// Errors and unknown codes go straight to the result and peek only reads the top;
// insert first finds the lowest free handle by a linear handle scan. Insert, update,
// remove top and remove by handle then sift, except a remove of the last entry;
// each sift step moves one level, at most 6 levels at 64 entries.
// Throughput: one transaction at a time; busy drops in the result cycle. No receiver stall.
// Reset: synchronous; queue empties, all handles free, max-first order.
// ----------------------------------------------------------------------------
// indexed_heap_priority_queue_top
// Handle-indexed binary heap priority queue with APB-style control register.
// ----------------------------------------------------------------------------
module indexed_heap_priority_queue_top import ihpq_pkg::*; #(
   parameter int Capacity = DefCapacity,
   parameter int KeyBits  = DefKeyBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_opcode,
   input  logic [KeyPortBits-1:0] req_key,
   input  logic [HandleBits-1:0]  req_handle,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [HandleBits-1:0]  rsp_out_handle,
   output logic [KeyPortBits-1:0] rsp_out_key,
   output logic [CountBits-1:0]   rsp_count,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic                   paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   logic    min_first_ff;
   ctl_type ctl;
   sts_type sts;

   assign pready = 1'b1;
   assign prdata = paddr ? 32'd0 : {31'd0, min_first_ff};

   always_ff @(posedge clock) begin
      if (reset) min_first_ff <= 1'b0;
      else if (psel && penable && pwrite && !paddr) min_first_ff <= pwdata[0];
   end

   ihpq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .busy(busy), .ctl(ctl));

   ihpq_dp #(.Capacity(Capacity), .KeyBits(KeyBits)) u_dp (
      .clock(clock), .reset(reset), .min_first(min_first_ff),
      .req_opcode(req_opcode), .req_key(req_key), .req_handle(req_handle),
      .ctl(ctl), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_out_handle(rsp_out_handle), .rsp_out_key(rsp_out_key),
      .rsp_count(rsp_count));
endmodule
